>>> rtl/core/rv32ie_pkg.sv
package rv32ie_pkg;

  // Data path width and default register file depth.
  localparam int XLEN     = 32;
  localparam int NUM_REGS = 32;
  localparam int REG_AW   = 5;

  // Register index of the return address (ra).
  localparam logic [REG_AW-1:0] RA_IDX = 5'd1;

  // Operation codes of one input word.
  typedef enum logic [4:0] {
    ACT_ADD   = 5'd0,
    ACT_SUB   = 5'd1,
    ACT_SLL   = 5'd2,
    ACT_SLT   = 5'd3,
    ACT_SLTU  = 5'd4,
    ACT_XOR   = 5'd5,
    ACT_SRL   = 5'd6,
    ACT_SRA   = 5'd7,
    ACT_OR    = 5'd8,
    ACT_AND   = 5'd9,
    ACT_ADDI  = 5'd10,
    ACT_SLTI  = 5'd11,
    ACT_SLTIU = 5'd12,
    ACT_XORI  = 5'd13,
    ACT_ORI   = 5'd14,
    ACT_ANDI  = 5'd15,
    ACT_SLLI  = 5'd16,
    ACT_SRLI  = 5'd17,
    ACT_SRAI  = 5'd18,
    ACT_JALR  = 5'd19,
    ACT_BEQ   = 5'd20,
    ACT_BNE   = 5'd21,
    ACT_BLT   = 5'd22,
    ACT_BGE   = 5'd23,
    ACT_BLTU  = 5'd24,
    ACT_BGEU  = 5'd25,
    ACT_LUI   = 5'd26,
    ACT_AUIPC = 5'd27,
    ACT_JAL   = 5'd28
  } action_t;

  // Internal ALU functions.
  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SLL,
    ALU_SLT,
    ALU_SLTU,
    ALU_XOR,
    ALU_SRL,
    ALU_SRA,
    ALU_OR,
    ALU_AND
  } alu_op_t;

  // One decoded instruction word.
  typedef struct packed {
    logic [4:0]        action;
    logic [REG_AW-1:0] dest_reg;
    logic [REG_AW-1:0] src1_reg;
    logic [REG_AW-1:0] src2_reg;
    logic [20:0]       raw_imm;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic [REG_AW-1:0] wb_index;
    logic [XLEN-1:0]   wb_value;
    logic              wb_valid;
    logic              branch_taken;
    logic              halt;
  } out_word_t;

  // Outcome of the execute logic for one instruction.
  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic [XLEN-1:0] value;
    logic            wr;
    logic            taken;
  } exec_t;

endpackage

>>> rtl/core/rv32ie_regfile.sv
module rv32ie_regfile #(
  parameter int NUM_REGS = rv32ie_pkg::NUM_REGS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [rv32ie_pkg::REG_AW-1:0] rd_addr1,
  input  logic [rv32ie_pkg::REG_AW-1:0] rd_addr2,
  output logic [rv32ie_pkg::XLEN-1:0]   rd_data1,
  output logic [rv32ie_pkg::XLEN-1:0]   rd_data2,
  input  logic                          wr_en,
  input  logic [rv32ie_pkg::REG_AW-1:0] wr_addr,
  input  logic [rv32ie_pkg::XLEN-1:0]   wr_data
);

  localparam int AW = $clog2(NUM_REGS);
  localparam logic [rv32ie_pkg::REG_AW:0] NREG = (rv32ie_pkg::REG_AW+1)'(NUM_REGS);

  logic [rv32ie_pkg::XLEN-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0]           vld_r;
  logic [rv32ie_pkg::XLEN-1:0]   q1_r, q2_r;
  logic                          ok1_r, ok2_r;
  logic [rv32ie_pkg::REG_AW-1:0] ra1_r, ra2_r;
  logic                          fwd_vld_r;
  logic [rv32ie_pkg::REG_AW-1:0] fwd_addr_r;
  logic [rv32ie_pkg::XLEN-1:0]   fwd_data_r;
  logic                          ok1_nxt, ok2_nxt;

  // An entry reads as zero for x0, beyond the depth, or before its first write.
  always_comb begin
    ok1_nxt = ({1'b0, rd_addr1} < NREG) && (rd_addr1 != '0) && vld_r[rd_addr1[AW-1:0]];
    ok2_nxt = ({1'b0, rd_addr2} < NREG) && (rd_addr2 != '0) && vld_r[rd_addr2[AW-1:0]];
  end

  // Storage array with registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      q1_r <= mem[rd_addr1[AW-1:0]];
      q2_r <= mem[rd_addr2[AW-1:0]];
    end
  end

  // Valid bits, read qualifiers and the last write kept for bypass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fwd_vld_r <= 1'b0;
      ok1_r     <= 1'b0;
      ok2_r     <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr[AW-1:0]] <= 1'b1;
        fwd_vld_r              <= 1'b1;
      end
      if (rd_en) begin
        ok1_r <= ok1_nxt;
        ok2_r <= ok2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
    if (rd_en) begin
      ra1_r <= rd_addr1;
      ra2_r <= rd_addr2;
    end
  end

  // A write landing on the same edge as the read is bypassed around the array.
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == ra1_r)) begin
      rd_data1 = fwd_data_r;
    end else begin
      rd_data1 = ok1_r ? q1_r : '0;
    end
    if (fwd_vld_r && (fwd_addr_r == ra2_r)) begin
      rd_data2 = fwd_data_r;
    end else begin
      rd_data2 = ok2_r ? q2_r : '0;
    end
  end

endmodule

>>> rtl/core/rv32ie_alu.sv
module rv32ie_alu (
  input  logic [4:0]                  action,
  input  logic [20:0]                 raw_imm,
  input  logic [rv32ie_pkg::XLEN-1:0] op_a,
  input  logic [rv32ie_pkg::XLEN-1:0] op_b,
  input  logic [rv32ie_pkg::XLEN-1:0] pc,
  output rv32ie_pkg::exec_t           res
);

  rv32ie_pkg::action_t         act;
  rv32ie_pkg::alu_op_t         op;
  logic                        use_imm;
  logic [rv32ie_pkg::XLEN-1:0] imm_i, imm_b, imm_u, imm_j;
  logic [rv32ie_pkg::XLEN-1:0] rhs, alu_res, pc_plus4, pc_off, pc_rel, jalr_sum;
  logic [4:0]                  shamt;
  logic                        eq, lt, ltu, cond;

  assign act = rv32ie_pkg::action_t'(action);

  // Immediate formats.
  always_comb begin
    imm_i = {{20{raw_imm[11]}}, raw_imm[11:0]};
    imm_b = {{19{raw_imm[12]}}, raw_imm[12:0]};
    imm_u = {raw_imm[19:0], 12'b0};
    imm_j = {{11{raw_imm[20]}}, raw_imm[20:0]};
  end

  // ALU function decode.
  always_comb begin
    use_imm = 1'b0;
    unique case (act) inside
      rv32ie_pkg::ACT_ADDI, rv32ie_pkg::ACT_SLTI, rv32ie_pkg::ACT_SLTIU,
      rv32ie_pkg::ACT_XORI, rv32ie_pkg::ACT_ORI, rv32ie_pkg::ACT_ANDI,
      rv32ie_pkg::ACT_SLLI, rv32ie_pkg::ACT_SRLI, rv32ie_pkg::ACT_SRAI: use_imm = 1'b1;
      default: use_imm = 1'b0;
    endcase
  end

  always_comb begin
    unique case (act) inside
      rv32ie_pkg::ACT_SUB:                          op = rv32ie_pkg::ALU_SUB;
      rv32ie_pkg::ACT_SLL, rv32ie_pkg::ACT_SLLI:    op = rv32ie_pkg::ALU_SLL;
      rv32ie_pkg::ACT_SLT, rv32ie_pkg::ACT_SLTI:    op = rv32ie_pkg::ALU_SLT;
      rv32ie_pkg::ACT_SLTU, rv32ie_pkg::ACT_SLTIU:  op = rv32ie_pkg::ALU_SLTU;
      rv32ie_pkg::ACT_XOR, rv32ie_pkg::ACT_XORI:    op = rv32ie_pkg::ALU_XOR;
      rv32ie_pkg::ACT_SRL, rv32ie_pkg::ACT_SRLI:    op = rv32ie_pkg::ALU_SRL;
      rv32ie_pkg::ACT_SRA, rv32ie_pkg::ACT_SRAI:    op = rv32ie_pkg::ALU_SRA;
      rv32ie_pkg::ACT_OR, rv32ie_pkg::ACT_ORI:      op = rv32ie_pkg::ALU_OR;
      rv32ie_pkg::ACT_AND, rv32ie_pkg::ACT_ANDI:    op = rv32ie_pkg::ALU_AND;
      default:                                      op = rv32ie_pkg::ALU_ADD;
    endcase
  end

  // Integer ALU.
  always_comb begin
    rhs   = use_imm ? imm_i : op_b;
    shamt = rhs[4:0];
    unique case (op)
      rv32ie_pkg::ALU_SUB:  alu_res = op_a - rhs;
      rv32ie_pkg::ALU_SLL:  alu_res = op_a << shamt;
      rv32ie_pkg::ALU_SLT:  alu_res = {31'b0, $signed(op_a) < $signed(rhs)};
      rv32ie_pkg::ALU_SLTU: alu_res = {31'b0, op_a < rhs};
      rv32ie_pkg::ALU_XOR:  alu_res = op_a ^ rhs;
      rv32ie_pkg::ALU_SRL:  alu_res = op_a >> shamt;
      rv32ie_pkg::ALU_SRA:  alu_res = $unsigned($signed(op_a) >>> shamt);
      rv32ie_pkg::ALU_OR:   alu_res = op_a | rhs;
      rv32ie_pkg::ALU_AND:  alu_res = op_a & rhs;
      default:              alu_res = op_a + rhs;
    endcase
  end

  // Branch compare and program counter arithmetic.
  always_comb begin
    eq  = (op_a == op_b);
    lt  = ($signed(op_a) < $signed(op_b));
    ltu = (op_a < op_b);
    unique case (act)
      rv32ie_pkg::ACT_BEQ:  cond = eq;
      rv32ie_pkg::ACT_BNE:  cond = !eq;
      rv32ie_pkg::ACT_BLT:  cond = lt;
      rv32ie_pkg::ACT_BGE:  cond = !lt;
      rv32ie_pkg::ACT_BLTU: cond = ltu;
      rv32ie_pkg::ACT_BGEU: cond = !ltu;
      default:              cond = 1'b0;
    endcase
    pc_plus4 = pc + 32'd4;
    if (act == rv32ie_pkg::ACT_JAL) begin
      pc_off = imm_j;
    end else if (act == rv32ie_pkg::ACT_AUIPC) begin
      pc_off = imm_u;
    end else begin
      pc_off = imm_b;
    end
    pc_rel   = pc + pc_off;
    jalr_sum = op_a + imm_i;
  end

  // Result selection by instruction class.
  always_comb begin
    res.next_pc = pc_plus4;
    res.value   = '0;
    res.wr      = 1'b0;
    res.taken   = 1'b0;
    unique case (act) inside
      [rv32ie_pkg::ACT_ADD:rv32ie_pkg::ACT_SRAI]: begin
        res.value = alu_res;
        res.wr    = 1'b1;
      end
      rv32ie_pkg::ACT_JALR: begin
        res.next_pc = {jalr_sum[31:1], 1'b0};
        res.value   = pc_plus4;
        res.wr      = 1'b1;
        res.taken   = 1'b1;
      end
      [rv32ie_pkg::ACT_BEQ:rv32ie_pkg::ACT_BGEU]: begin
        if (cond) begin
          res.next_pc = pc_rel;
          res.taken   = 1'b1;
        end
      end
      rv32ie_pkg::ACT_LUI: begin
        res.value = imm_u;
        res.wr    = 1'b1;
      end
      rv32ie_pkg::ACT_AUIPC: begin
        res.value = pc_rel;
        res.wr    = 1'b1;
      end
      rv32ie_pkg::ACT_JAL: begin
        res.next_pc = pc_rel;
        res.value   = pc_plus4;
        res.wr      = 1'b1;
        res.taken   = 1'b1;
      end
      default: begin
        res.wr = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/rv32i_integer_execute_unit.sv
// Channel  | Ports                             | Direction | Word
// ---------+-----------------------------------+-----------+-----------------------
// input    | in_valid, in_stall, in_data       | in        | rv32ie_pkg::in_word_t
// result   | out_valid, out_stall, out_data    | out       | rv32ie_pkg::out_word_t
// config   | cfg_valid, cfg_ready, cfg_data    | in        | start_pc, 32 bits
//
// The result word is registered after its instruction is accepted: the accepting edge captures
// the word and its register file reads, and the ALU outcome is loaded when the word executes.
// One instruction is accepted per cycle unless the output stalls; a write-back is bypassed to the next word.
// Synchronous active-low reset clears the register file valid bits and sets PC to 0.
// A stalled output register holds its word; the input stalls while a full execute stage cannot drain.
// A start_pc write loads the program counter and is taken only while the unit is empty.
module rv32i_integer_execute_unit #(
  parameter int NUM_REGS = rv32ie_pkg::NUM_REGS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rv32ie_pkg::in_word_t        in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rv32ie_pkg::out_word_t       out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rv32ie_pkg::XLEN-1:0] cfg_data
);

  localparam logic [rv32ie_pkg::REG_AW:0] NREG = (rv32ie_pkg::REG_AW+1)'(NUM_REGS);

  logic                        s1_vld_r;
  rv32ie_pkg::in_word_t        s1_word_r;
  logic [rv32ie_pkg::XLEN-1:0] pc_r;
  logic [rv32ie_pkg::XLEN-1:0] ra_r, ra_nxt;
  logic                        out_vld_r;
  rv32ie_pkg::out_word_t       out_word_r, out_word_nxt;
  logic                        in_fire, ex_fire, wb_en;
  logic [rv32ie_pkg::XLEN-1:0] op_a, op_b;
  rv32ie_pkg::exec_t           ex;

  // Handshake: the execute stage moves when the output register is free or drains.
  always_comb begin
    ex_fire   = s1_vld_r && (!out_vld_r || !out_stall);
    in_stall  = s1_vld_r && !ex_fire;
    in_fire   = in_valid && !in_stall;
    cfg_ready = !s1_vld_r && !out_vld_r;
  end

  // Register file, read when a word is accepted and written when it executes.
  rv32ie_regfile #(
    .NUM_REGS(NUM_REGS)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr1 (in_data.src1_reg),
    .rd_addr2 (in_data.src2_reg),
    .rd_data1 (op_a),
    .rd_data2 (op_b),
    .wr_en    (wb_en),
    .wr_addr  (s1_word_r.dest_reg),
    .wr_data  (ex.value)
  );

  rv32ie_alu u_alu (
    .action  (s1_word_r.action),
    .raw_imm (s1_word_r.raw_imm),
    .op_a    (op_a),
    .op_b    (op_b),
    .pc      (pc_r),
    .res     (ex)
  );

  // Write-back qualification, ra shadow and the result word.
  always_comb begin
    wb_en = ex_fire && ex.wr && (s1_word_r.dest_reg != '0) &&
            ({1'b0, s1_word_r.dest_reg} < NREG);
    ra_nxt = (wb_en && (s1_word_r.dest_reg == rv32ie_pkg::RA_IDX)) ? ex.value : ra_r;
    out_word_nxt.next_pc      = ex.next_pc;
    out_word_nxt.wb_index     = wb_en ? s1_word_r.dest_reg : '0;
    out_word_nxt.wb_value     = wb_en ? ex.value : '0;
    out_word_nxt.wb_valid     = wb_en;
    out_word_nxt.branch_taken = ex.taken;
    out_word_nxt.halt         = (s1_word_r.action == rv32ie_pkg::ACT_JALR) && (ra_nxt == '0);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= '0;
      ra_r      <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (ex_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (ex_fire) begin
        out_vld_r <= 1'b1;
        pc_r      <= ex.next_pc;
        ra_r      <= ra_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        pc_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_data;
    end
    if (ex_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  // A reported write-back never targets x0.
  a_wb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_word_r.wb_valid) |-> (out_word_r.wb_index != '0))
    else $error("write-back reported for x0");

  // Without a write-back the index and value read as zero.
  a_wb_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_word_r.wb_valid) |->
      ((out_word_r.wb_index == '0) && (out_word_r.wb_value == '0)))
    else $error("stale write-back fields");

  // Halt only comes from a jump, which always redirects control flow.
  a_halt_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_word_r.halt) |-> out_word_r.branch_taken)
    else $error("halt without redirect");

  // An executed word always lands in the output register.
  a_exec_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire |=> out_vld_r)
    else $error("executed word lost");

endmodule
